// ===== src/dtpb_pkg.sv =====
package dtpb_pkg;

    localparam int DEF_FRAME_WIDTH   = 640;
    localparam int DEF_FRAME_HEIGHT  = 480;
    localparam int DEF_INV_FRAC_BITS = 24;

    localparam int DEPTH_W    = 16;
    localparam int POS_W      = 26;
    localparam int IDX_W      = 19;
    localparam int CNT_W      = 10;
    localparam int MAG_W      = 10;
    localparam int INV_W      = 24;
    localparam int CORNER_W   = 9;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 88;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_MIN_DEPTH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_DEPTH   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_COL  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_CENTER_ROW  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL_X = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_INV_FOCAL_Y = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_CORNER_SIZE = 3'd6;

    localparam logic [DEPTH_W-1:0]  RST_MIN_DEPTH   = 16'd400;
    localparam logic [DEPTH_W-1:0]  RST_MAX_DEPTH   = 16'd3500;
    localparam logic [CNT_W-1:0]    RST_CENTER_COL  = 10'd320;
    localparam logic [CNT_W-1:0]    RST_CENTER_ROW  = 10'd240;
    localparam logic [INV_W-1:0]    RST_INV_FOCAL   = 24'd28926;
    localparam logic [CORNER_W-1:0] RST_CORNER_SIZE = 9'd50;

    typedef struct packed {
        logic [DEPTH_W-1:0]  min_depth;
        logic [DEPTH_W-1:0]  max_depth;
        logic [CNT_W-1:0]    center_col;
        logic [CNT_W-1:0]    center_row;
        logic [INV_W-1:0]    inv_focal_x;
        logic [INV_W-1:0]    inv_focal_y;
        logic [CORNER_W-1:0] corner_size;
    } t_cfg;

    // one accepted point, offsets in sign/magnitude form
    typedef struct packed {
        logic               neg_x;
        logic [MAG_W-1:0]   mag_x;
        logic               neg_y;
        logic [MAG_W-1:0]   mag_y;
        logic [DEPTH_W-1:0] depth;
        logic [IDX_W-1:0]   index;
    } t_job;

endpackage

// ===== src/dtpb_front.sv =====
module dtpb_front import dtpb_pkg::*; #(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [DEPTH_W-1:0] i_depth,
    input  logic               i_frame_start,
    input  logic               i_full,
    output logic               o_push,
    output t_job               o_job
);

    localparam logic signed [CNT_W+1:0] W_S = (CNT_W+2)'(FRAME_WIDTH);
    localparam logic signed [CNT_W+1:0] H_S = (CNT_W+2)'(FRAME_HEIGHT);
    localparam logic [CNT_W:0] W_U = (CNT_W+1)'(FRAME_WIDTH);
    localparam logic [CNT_W:0] H_U = (CNT_W+1)'(FRAME_HEIGHT);

    logic [CNT_W-1:0] r_col, n_col, r_row, n_row;
    logic [IDX_W-1:0] r_emit, n_emit;

    logic [CNT_W-1:0] col_cur, row_cur;
    logic [IDX_W-1:0] emit_cur;
    logic accept, in_range, outside, keep;
    logic signed [CNT_W+1:0] c_s, k_s, r_s, wc, hc;
    logic signed [CNT_W:0] off_x, off_y, neg_off_x, neg_off_y;
    logic [CNT_W:0] col_inc, row_inc;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        col_cur  = i_frame_start ? '0 : r_col;
        row_cur  = i_frame_start ? '0 : r_row;
        emit_cur = i_frame_start ? '0 : r_emit;

        in_range = (i_cfg.min_depth < i_depth) && (i_depth < i_cfg.max_depth);

        c_s = {3'b000, i_cfg.corner_size};
        k_s = {2'b00, col_cur};
        r_s = {2'b00, row_cur};
        wc  = W_S - c_s;
        hc  = H_S - c_s;
        outside = (wc > k_s || hc > r_s) && (c_s < k_s || c_s < r_s) &&
                  (wc > k_s || c_s < r_s) && (hc > r_s || c_s < k_s);
        keep = in_range && outside;

        off_x = $signed({1'b0, col_cur}) - $signed({1'b0, i_cfg.center_col});
        off_y = $signed({1'b0, row_cur}) - $signed({1'b0, i_cfg.center_row});
        neg_off_x = -off_x;
        neg_off_y = -off_y;

        o_job.neg_x = off_x[CNT_W];
        o_job.mag_x = off_x[CNT_W] ? neg_off_x[MAG_W-1:0] : off_x[MAG_W-1:0];
        o_job.neg_y = off_y[CNT_W];
        o_job.mag_y = off_y[CNT_W] ? neg_off_y[MAG_W-1:0] : off_y[MAG_W-1:0];
        o_job.depth = i_depth;
        o_job.index = emit_cur;
        o_push = accept && keep;

        // raster advance after the sample
        col_inc = {1'b0, col_cur} + 1'b1;
        row_inc = {1'b0, row_cur} + 1'b1;
        n_col  = r_col;
        n_row  = r_row;
        n_emit = r_emit;
        if (accept) begin
            n_emit = emit_cur + IDX_W'(keep);
            n_row  = row_cur;
            if (col_inc >= W_U) begin
                n_col = '0;
                if (row_inc >= H_U) begin
                    n_row  = '0;
                    n_emit = '0;
                end else begin
                    n_row = row_inc[CNT_W-1:0];
                end
            end else begin
                n_col = col_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_emit <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_emit <= n_emit;
        end
    end

endmodule

// ===== src/dtpb_queue.sv =====
module dtpb_queue import dtpb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);

    t_job r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W_Q-1:0] r_cnt;
    logic do_pop;

    assign o_full  = (r_cnt == CNT_W_Q'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W_Q'(i_push) - CNT_W_Q'(do_pop);
        end
    end

endmodule

// ===== src/dtpb_back.sv =====
module dtpb_back import dtpb_pkg::*; #(
    parameter int INV_FRAC_BITS = DEF_INV_FRAC_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_empty,
    input  t_job                 i_job,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [POS_W-1:0]     o_pos_x,
    output logic [POS_W-1:0]     o_pos_y,
    output logic [DEPTH_W-1:0]   o_pos_z,
    output logic [IDX_W-1:0]     o_index
);

    localparam int P1_W = MAG_W + DEPTH_W;
    localparam int P2_W = P1_W + INV_W;
    localparam logic [P2_W-1:0] POS_LIM = P2_W'(1) << (POS_W - 1);

    function automatic logic [POS_W-1:0] sat_whole(input logic neg,
                                                   input logic [P2_W-1:0] prod);
        logic [P2_W-1:0] whole;
        logic [POS_W-1:0] low;
        whole = prod >> INV_FRAC_BITS;
        low   = whole[POS_W-1:0];
        if (neg) begin
            sat_whole = (whole > POS_LIM) ? POS_LIM[POS_W-1:0] : -low;
        end else begin
            sat_whole = (whole >= POS_LIM) ? (POS_LIM[POS_W-1:0] - 1'b1) : low;
        end
    endfunction

    logic en;
    logic r_v1, r_v2, r_v3;
    logic r_neg_x1, r_neg_y1, r_neg_x2, r_neg_y2;
    logic [P1_W-1:0] r_p1_x, r_p1_y;
    logic [P2_W-1:0] r_p2_x, r_p2_y;
    logic [DEPTH_W-1:0] r_z1, r_z2;
    logic [IDX_W-1:0]   r_idx1, r_idx2;

    // whole pipe moves together, held only by a waiting result
    assign en      = !r_v3 || i_ready;
    assign o_pop   = en && !i_empty;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= !i_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_x   <= P1_W'(i_job.mag_x) * P1_W'(i_job.depth);
            r_p1_y   <= P1_W'(i_job.mag_y) * P1_W'(i_job.depth);
            r_neg_x1 <= i_job.neg_x;
            r_neg_y1 <= i_job.neg_y;
            r_z1     <= i_job.depth;
            r_idx1   <= i_job.index;

            r_p2_x   <= P2_W'(r_p1_x) * P2_W'(i_cfg.inv_focal_x);
            r_p2_y   <= P2_W'(r_p1_y) * P2_W'(i_cfg.inv_focal_y);
            r_neg_x2 <= r_neg_x1;
            r_neg_y2 <= r_neg_y1;
            r_z2     <= r_z1;
            r_idx2   <= r_idx1;

            o_pos_x  <= sat_whole(r_neg_x2, r_p2_x);
            o_pos_y  <= sat_whole(r_neg_y2, r_p2_y);
            o_pos_z  <= r_z2;
            o_index  <= r_idx2;
        end
    end

endmodule

// ===== src/depth_to_point_backprojector.sv =====
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: depth; tuser: frame_start
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: pos_x, pos_y, pos_z, point_index
// cfg       in   i_cfg_we (no handshake)      i_cfg_addr, i_cfg_wdata
//
// One sample per cycle in while the queue is not full, at most one point per cycle out.
// A kept sample is written into the 4-entry queue, then passes two multiplier stages
// and an output register before it shows on m_axis.
// Reset is synchronous; once i_rst_n has been sampled low, the block takes samples.
// A stalled output holds the multiplier pipe; the queue absorbs 4 more points
// before s_axis_tready drops.
module depth_to_point_backprojector import dtpb_pkg::*; #(
    parameter int FRAME_WIDTH   = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT  = DEF_FRAME_HEIGHT,
    parameter int INV_FRAC_BITS = DEF_INV_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [15:0] depth
    input  logic [0:0]            s_axis_tuser,   // [0] frame_start
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // pos_x, pos_y, pos_z, point_index, pad
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg r_cfg;
    t_job front_job, queue_job;
    logic push, pop, full, empty;
    logic [POS_W-1:0]   pos_x, pos_y;
    logic [DEPTH_W-1:0] pos_z;
    logic [IDX_W-1:0]   point_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_depth   <= RST_MIN_DEPTH;
            r_cfg.max_depth   <= RST_MAX_DEPTH;
            r_cfg.center_col  <= RST_CENTER_COL;
            r_cfg.center_row  <= RST_CENTER_ROW;
            r_cfg.inv_focal_x <= RST_INV_FOCAL;
            r_cfg.inv_focal_y <= RST_INV_FOCAL;
            r_cfg.corner_size <= RST_CORNER_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MIN_DEPTH:   r_cfg.min_depth   <= i_cfg_wdata[DEPTH_W-1:0];
                REG_MAX_DEPTH:   r_cfg.max_depth   <= i_cfg_wdata[DEPTH_W-1:0];
                REG_CENTER_COL:  r_cfg.center_col  <= i_cfg_wdata[CNT_W-1:0];
                REG_CENTER_ROW:  r_cfg.center_row  <= i_cfg_wdata[CNT_W-1:0];
                REG_INV_FOCAL_X: r_cfg.inv_focal_x <= i_cfg_wdata[INV_W-1:0];
                REG_INV_FOCAL_Y: r_cfg.inv_focal_y <= i_cfg_wdata[INV_W-1:0];
                REG_CORNER_SIZE: r_cfg.corner_size <= i_cfg_wdata[CORNER_W-1:0];
                default: ;
            endcase
        end
    end

    dtpb_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_depth       (s_axis_tdata[DEPTH_W-1:0]),
        .i_frame_start (s_axis_tuser[0]),
        .i_full        (full),
        .o_push        (push),
        .o_job         (front_job)
    );

    dtpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (queue_job)
    );

    dtpb_back #(
        .INV_FRAC_BITS (INV_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (empty),
        .i_job   (queue_job),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pos_x (pos_x),
        .o_pos_y (pos_y),
        .o_pos_z (pos_z),
        .o_index (point_index)
    );

    assign m_axis_tdata = {1'b0, point_index, pos_z, pos_y, pos_x};

endmodule

// ===== src/dtpb_checker.sv =====
module dtpb_checker import dtpb_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int Z_LO = 2 * POS_W;

    // reset empties the output side
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // a point passed the exclusive lower bound, so its depth is never zero
    a_depth_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[Z_LO+DEPTH_W-1:Z_LO] != '0)
        else $error("point with zero depth");

    // queue space only shrinks on an accepted sample
    a_ready_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready && !s_axis_tvalid |=> s_axis_tready)
        else $error("input ready dropped without a request");

endmodule

bind depth_to_point_backprojector dtpb_checker u_dtpb_checker (.*);
